// ===== rtl/fpxc_pkg.sv =====
// fpxc_pkg: shared types and constants of the frame parser with xor checksum
// used by fpxc_step and frame_parser_xor_checksum_top; depends on nothing else

package fpxc_pkg;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 6;
   localparam int SEQ_W    = 5;
   localparam int FTYPE_W  = 5;
   localparam int STATUS_W = 2;

   // result tdata layout, lowest bit first, padded to whole bytes
   localparam int RSP_PAYLOAD_LSB = 0;
   localparam int RSP_MARKER_LSB  = RSP_PAYLOAD_LSB + BYTE_W;
   localparam int RSP_SEQ_LSB     = RSP_MARKER_LSB + BYTE_W;
   localparam int RSP_FTYPE_LSB   = RSP_SEQ_LSB + SEQ_W;
   localparam int RSP_LEN_LSB     = RSP_FTYPE_LSB + FTYPE_W;
   localparam int RSP_STATUS_LSB  = RSP_LEN_LSB + LEN_W;
   localparam int RSP_FIELDS_W    = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_TDATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;

   // reset value of the length limit register
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 6'd63;

   // item kinds on the result channel
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // frame parse phase
   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_HDR1 = 3'd1,
      PH_HDR2 = 3'd2,
      PH_DATA = 3'd3,
      PH_SUM  = 3'd4
   } phase_type;

   // end of frame status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_LEN_LARGE = 2'd1,
      ST_LEN_ZERO  = 2'd2,
      ST_SUM_BAD   = 2'd3
   } status_type;

   // one result item
   typedef struct packed {
      logic                item_kind;
      logic [BYTE_W-1:0]   payload_byte;
      logic [BYTE_W-1:0]   marker_seen;
      logic [SEQ_W-1:0]    seq_number;
      logic [FTYPE_W-1:0]  frame_type;
      logic [LEN_W-1:0]    payload_len;
      status_type          status;
      logic                last;
   } result_type;

endpackage

// ===== rtl/fpxc_step.sv =====
// fpxc_step: per-byte frame parse, holds the frame state and builds one result
// depends on fpxc_pkg

module fpxc_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [fpxc_pkg::BYTE_W-1:0]   in_byte,
   input  logic                          frame_start,
   input  logic [fpxc_pkg::LEN_W-1:0]    max_data_len,
   output logic                          res_valid,
   output fpxc_pkg::result_type          res
);

   fpxc_pkg::phase_type            phase_ff, phase_in;
   logic [fpxc_pkg::BYTE_W-1:0]    marker_ff, marker_in;
   logic [fpxc_pkg::LEN_W-1:0]     length_ff, length_in;
   logic [fpxc_pkg::SEQ_W-1:0]     seq_ff, seq_in;
   logic [fpxc_pkg::FTYPE_W-1:0]   ftype_ff, ftype_in;
   logic [fpxc_pkg::LEN_W-1:0]     left_ff, left_in;
   logic [fpxc_pkg::BYTE_W-1:0]    xor_ff, xor_in;
   logic [fpxc_pkg::LEN_W-1:0]     left_dec;
   logic                           len_bad;

   assign left_dec = left_ff - fpxc_pkg::LEN_W'(1);
   assign len_bad  = (length_ff > max_data_len) || (length_ff == '0);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step_en) begin
         if (frame_start) begin
            phase_in = fpxc_pkg::PH_HDR1;
         end else begin
            case (phase_ff)
               fpxc_pkg::PH_HDR1: phase_in = fpxc_pkg::PH_HDR2;
               fpxc_pkg::PH_HDR2: phase_in = len_bad ? fpxc_pkg::PH_IDLE : fpxc_pkg::PH_DATA;
               fpxc_pkg::PH_DATA: begin
                  if (left_dec == '0) phase_in = fpxc_pkg::PH_SUM;
               end
               fpxc_pkg::PH_SUM:  phase_in = fpxc_pkg::PH_IDLE;
               default:           phase_in = fpxc_pkg::PH_IDLE;
            endcase
         end
      end
   end

   // frame fields, running xor and the result item
   always_comb begin
      marker_in = marker_ff;
      length_in = length_ff;
      seq_in    = seq_ff;
      ftype_in  = ftype_ff;
      left_in   = left_ff;
      xor_in    = xor_ff;
      res_valid = 1'b0;
      if (step_en) begin
         if (frame_start) begin
            marker_in = in_byte;
            xor_in    = '0;
         end else begin
            case (phase_ff)
               fpxc_pkg::PH_HDR1: begin
                  length_in = in_byte[7:2];
                  seq_in    = {in_byte[1:0], 3'b000};
                  xor_in    = xor_ff ^ in_byte;
               end
               fpxc_pkg::PH_HDR2: begin
                  seq_in    = {seq_ff[4:3], in_byte[7:5]};
                  ftype_in  = in_byte[4:0];
                  xor_in    = xor_ff ^ in_byte;
                  left_in   = length_ff;
                  res_valid = len_bad;
               end
               fpxc_pkg::PH_DATA: begin
                  xor_in    = xor_ff ^ in_byte;
                  left_in   = left_dec;
                  res_valid = 1'b1;
               end
               fpxc_pkg::PH_SUM: begin
                  res_valid = 1'b1;
               end
               default: begin
                  res_valid = 1'b0;
               end
            endcase
         end
      end

      // status item unless a data byte is passed on
      res.item_kind    = fpxc_pkg::KIND_STATUS;
      res.payload_byte = '0;
      res.marker_seen  = marker_ff;
      res.seq_number   = seq_in;
      res.frame_type   = ftype_in;
      res.payload_len  = length_ff;
      res.last         = 1'b1;
      if (length_ff > max_data_len) begin
         res.status = fpxc_pkg::ST_LEN_LARGE;
      end else if (length_ff == '0) begin
         res.status = fpxc_pkg::ST_LEN_ZERO;
      end else begin
         res.status = fpxc_pkg::ST_OK;
      end
      if (phase_ff == fpxc_pkg::PH_SUM) begin
         res.status = (in_byte == xor_ff) ? fpxc_pkg::ST_OK : fpxc_pkg::ST_SUM_BAD;
      end
      if (phase_ff == fpxc_pkg::PH_DATA) begin
         res.item_kind    = fpxc_pkg::KIND_DATA;
         res.payload_byte = in_byte;
         res.status       = fpxc_pkg::ST_OK;
         res.last         = 1'b0;
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= fpxc_pkg::PH_IDLE;
         marker_ff <= '0;
         length_ff <= '0;
         seq_ff    <= '0;
         ftype_ff  <= '0;
         left_ff   <= '0;
         xor_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         marker_ff <= marker_in;
         length_ff <= length_in;
         seq_ff    <= seq_in;
         ftype_ff  <= ftype_in;
         left_ff   <= left_in;
         xor_ff    <= xor_in;
      end
   end

endmodule

// ===== rtl/frame_parser_xor_checksum_top.sv =====
// frame_parser_xor_checksum_top: input register, parse step and result register
// depends on fpxc_pkg and fpxc_step
//
// Usage
//   req_*  : raw frame bytes, one item per byte; req_tuser set on the start
//            marker byte of every frame. A start always opens a new frame.
//   rsp_*  : one item per data byte (tuser 0), then one status item (tuser 1,
//            tlast 1) that closes the frame. The start marker, bytes outside
//            a frame and header bytes give no item, save a bad length's status.
//   csr_*  : write of the payload length limit; write only while idle.
// Timing
//   A byte taken sits in the input register and is parsed into the result
//   register once that is free or being emptied. One byte per cycle is
//   sustained while rsp_tready stays high; the frame state update is a
//   single pass through the parse step.
// Reset
//   Synchronous: both registers empty, parser idle, length limit 63.
// Stall
//   While rsp_tready is low with a result waiting, the input register still
//   takes one more byte; req_tready drops only when both registers are full.

module frame_parser_xor_checksum_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // input channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // in_byte
   input  logic                                  req_tuser,   // frame_start
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // payload_byte, marker_seen, seq_number, frame_type, payload_len, status, zero pad
   output logic [fpxc_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tuser,   // item_kind
   output logic                                  rsp_tlast,   // last
   // configuration
   input  logic                                  csr_we,
   input  logic [fpxc_pkg::LEN_W-1:0]            csr_wdata    // max_data_len
);

   logic                             in_valid_ff, in_valid_in;
   logic [fpxc_pkg::BYTE_W-1:0]      in_byte_ff;
   logic                             in_start_ff;
   logic                             out_valid_ff, out_valid_in;
   fpxc_pkg::result_type             out_ff;
   logic [fpxc_pkg::LEN_W-1:0]       max_len_ff;
   logic                             advance;
   logic                             req_take;
   logic                             res_valid;
   fpxc_pkg::result_type             res;

   // handshake control
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign req_take     = req_tvalid && req_tready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = (advance && res_valid) || (out_valid_ff && !rsp_tready);

   // length limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= fpxc_pkg::MAX_LEN_RESET;
      end else if (csr_we) begin
         max_len_ff <= csr_wdata;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
   end

   fpxc_step u_step (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .in_byte      (in_byte_ff),
      .frame_start  (in_start_ff),
      .max_data_len (max_len_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance && res_valid) begin
         out_ff <= res;
      end
   end

   // result packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.item_kind;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {{(fpxc_pkg::RSP_TDATA_W - fpxc_pkg::RSP_FIELDS_W){1'b0}},
                        out_ff.status, out_ff.payload_len, out_ff.frame_type,
                        out_ff.seq_number, out_ff.marker_seen, out_ff.payload_byte};

   // a status item and only a status item closes the frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == rsp_tuser))
      else $error("tlast does not match item kind");

   // data items always carry an ok status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == fpxc_pkg::KIND_DATA)) |->
      (out_ff.status == fpxc_pkg::ST_OK))
      else $error("data item with non-ok status");

   // a held input byte is not overwritten while the parser waits
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)
                                     && $stable(in_start_ff)))
      else $error("input register lost a waiting byte");

   // a zero length status reports a zero length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_ff.status == fpxc_pkg::ST_LEN_ZERO)) |->
      (out_ff.payload_len == '0))
      else $error("zero length status with nonzero length");

endmodule

// ===== tb/tb_frame_parser_xor_checksum_top.sv =====
// tb_frame_parser_xor_checksum_top: self-checking bench for the frame parser with xor checksum
// a directed table then random frames, each result checked against an in-bench frame decoder
// depends on fpxc_pkg and frame_parser_xor_checksum_top

module tb_frame_parser_xor_checksum_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 4;
   localparam int SHOWN_MISMATCHES = 10;

   // one row of the directed table
   typedef struct packed {
      bit                     cfg_write;
      logic [7:0]             data;
      logic                   start;
      bit                     pinned;
      fpxc_pkg::result_type   want;
   } stim_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [7:0]                        req_tdata = 8'h00;
   logic                              req_tuser = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [fpxc_pkg::RSP_TDATA_W-1:0]  rsp_tdata;
   logic                              rsp_tuser;
   logic                              rsp_tlast;
   logic                              csr_we = 1'b0;
   logic [fpxc_pkg::LEN_W-1:0]        csr_wdata = fpxc_pkg::MAX_LEN_RESET;

   // frame decoder state, mirrors the block after reset
   fpxc_pkg::phase_type           dec_phase = fpxc_pkg::PH_IDLE;
   logic [7:0]                    dec_marker = 8'h00;
   logic [fpxc_pkg::LEN_W-1:0]    dec_len = '0;
   logic [fpxc_pkg::LEN_W-1:0]    dec_left = '0;
   logic [fpxc_pkg::SEQ_W-1:0]    dec_seq = '0;
   logic [fpxc_pkg::FTYPE_W-1:0]  dec_ftype = '0;
   logic [7:0]                    dec_xor = 8'h00;
   logic [fpxc_pkg::LEN_W-1:0]    dec_limit = fpxc_pkg::MAX_LEN_RESET;

   fpxc_pkg::result_type   frame_items_q[$];
   stim_row_type           plan[$];
   int                     error_count = 0;
   int                     cycle_count = 0;
   int                     parsed_count = 0;
   int                     send_idle_pct = 6;
   int                     recv_idle_pct = 6;
   fpxc_pkg::result_type   got_item;
   fpxc_pkg::result_type   want_item;

   frame_parser_xor_checksum_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // build a result item from the current frame header
   function automatic fpxc_pkg::result_type frame_item(input logic kind,
                                                       input logic [7:0] data,
                                                       input fpxc_pkg::status_type st);
      fpxc_pkg::result_type r;
      r.item_kind    = kind;
      r.payload_byte = data;
      r.marker_seen  = dec_marker;
      r.seq_number   = dec_seq;
      r.frame_type   = dec_ftype;
      r.payload_len  = dec_len;
      r.status       = st;
      r.last         = kind;
      return r;
   endfunction

   // advance the decoder by one byte; returns 1 when the byte yields an item
   function automatic bit decode_byte(input logic [7:0] b, input logic s,
                                      output fpxc_pkg::result_type r, output bit ignored);
      bit has;
      has = 1'b0;
      ignored = 1'b0;
      r = '0;
      if (s) begin
         dec_marker = b;
         dec_xor = 8'h00;
         dec_phase = fpxc_pkg::PH_HDR1;
      end else begin
         case (dec_phase)
            fpxc_pkg::PH_HDR1: begin
               dec_len = b[7:2];
               dec_seq = {b[1:0], 3'b000};
               dec_xor = dec_xor ^ b;
               dec_phase = fpxc_pkg::PH_HDR2;
            end
            fpxc_pkg::PH_HDR2: begin
               dec_seq = dec_seq | {2'b00, b[7:5]};
               dec_ftype = b[4:0];
               dec_xor = dec_xor ^ b;
               // limit check wins over the zero check
               if (dec_len > dec_limit) begin
                  dec_phase = fpxc_pkg::PH_IDLE;
                  r = frame_item(fpxc_pkg::KIND_STATUS, 8'h00, fpxc_pkg::ST_LEN_LARGE);
                  has = 1'b1;
               end else if (dec_len == '0) begin
                  dec_phase = fpxc_pkg::PH_IDLE;
                  r = frame_item(fpxc_pkg::KIND_STATUS, 8'h00, fpxc_pkg::ST_LEN_ZERO);
                  has = 1'b1;
               end else begin
                  dec_left = dec_len;
                  dec_phase = fpxc_pkg::PH_DATA;
               end
            end
            fpxc_pkg::PH_DATA: begin
               dec_xor = dec_xor ^ b;
               dec_left = dec_left - 1'b1;
               if (dec_left == '0) dec_phase = fpxc_pkg::PH_SUM;
               r = frame_item(fpxc_pkg::KIND_DATA, b, fpxc_pkg::ST_OK);
               has = 1'b1;
            end
            fpxc_pkg::PH_SUM: begin
               dec_phase = fpxc_pkg::PH_IDLE;
               r = frame_item(fpxc_pkg::KIND_STATUS, 8'h00,
                              (b == dec_xor) ? fpxc_pkg::ST_OK : fpxc_pkg::ST_SUM_BAD);
               has = 1'b1;
            end
            default: begin
               dec_phase = fpxc_pkg::PH_IDLE;
               ignored = 1'b1;
            end
         endcase
      end
      return has;
   endfunction

   function automatic string fmt_item(input fpxc_pkg::result_type r);
      return $sformatf({"kind %0d byte %h marker %h seq %0d type %0d len %0d",
                        " status %0d last %0d"},
                       r.item_kind, r.payload_byte, r.marker_seen, r.seq_number,
                       r.frame_type, r.payload_len, r.status, r.last);
   endfunction

   task automatic note_error(input string what);
      error_count++;
      if (error_count <= SHOWN_MISMATCHES)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // directed table helpers
   task automatic add_byte(input logic [7:0] b, input logic s);
      stim_row_type row;
      row = '0;
      row.data = b;
      row.start = s;
      plan.push_back(row);
   endtask

   task automatic add_cfg(input logic [fpxc_pkg::LEN_W-1:0] v);
      stim_row_type row;
      row = '0;
      row.cfg_write = 1'b1;
      row.data = {2'b00, v};
      plan.push_back(row);
   endtask

   // header or checksum byte that closes the frame with a status known at a glance
   task automatic add_status(input logic [7:0] b, input logic [7:0] marker,
                             input logic [fpxc_pkg::SEQ_W-1:0] seq,
                             input logic [fpxc_pkg::FTYPE_W-1:0] ftype,
                             input logic [fpxc_pkg::LEN_W-1:0] len,
                             input fpxc_pkg::status_type st);
      stim_row_type row;
      row = '0;
      row.data = b;
      row.pinned = 1'b1;
      row.want.item_kind = fpxc_pkg::KIND_STATUS;
      row.want.payload_byte = 8'h00;
      row.want.marker_seen = marker;
      row.want.seq_number = seq;
      row.want.frame_type = ftype;
      row.want.payload_len = len;
      row.want.status = st;
      row.want.last = 1'b1;
      plan.push_back(row);
   endtask

   // drive one input item, wait for its handshake and record what it should yield
   task automatic send_item(input logic [7:0] b, input logic s, input bit pinned,
                            input fpxc_pkg::result_type want);
      fpxc_pkg::result_type r;
      bit has;
      bit ignored;
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= s;
      do @(posedge clock); while (!req_tready);
      has = decode_byte(b, s, r, ignored);
      if (!ignored) parsed_count++;
      if (has) frame_items_q.push_back(pinned ? want : r);
      @(negedge clock);
   endtask

   // hold the sender until every expected item has come out and the pipe is empty
   task automatic drain;
      req_tvalid <= 1'b0;
      while (frame_items_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [fpxc_pkg::LEN_W-1:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      dec_limit = v;
   endtask

   // stray bytes, now and then with a start flag
   task automatic send_noise;
      int n;
      int i;
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++)
         send_item(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 15, 1'b0, '0);
   endtask

   // one frame with random content, now and then cut short or with a bad checksum
   task automatic send_frame(input logic [fpxc_pkg::LEN_W-1:0] lim);
      logic [7:0]                    body[$];
      logic [7:0]                    sum;
      logic [fpxc_pkg::LEN_W-1:0]    len;
      logic [fpxc_pkg::SEQ_W-1:0]    seq;
      logic [fpxc_pkg::FTYPE_W-1:0]  ftype;
      int                            r;
      int                            top;
      int                            cut;
      int                            i;
      r = $urandom_range(0, 99);
      top = (lim < 10) ? int'(lim) : 10;
      if (r < 8) len = '0;
      else if (r < 18) len = fpxc_pkg::LEN_W'($urandom_range(0, 63));
      else if (r < 26) len = lim;
      else if (r < 32 && lim != 6'd63) len = lim + 1'b1;
      else if (r < 42) len = fpxc_pkg::LEN_W'($urandom_range(0, lim));
      else if (top == 0) len = '0;
      else len = fpxc_pkg::LEN_W'($urandom_range(1, top));
      seq = fpxc_pkg::SEQ_W'($urandom_range(0, 31));
      ftype = fpxc_pkg::FTYPE_W'($urandom_range(0, 31));
      body.push_back({len, seq[4:3]});
      body.push_back({seq[2:0], ftype});
      for (i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
      sum = 8'h00;
      for (i = 0; i < body.size(); i++) sum = sum ^ body[i];
      if ($urandom_range(0, 99) < 10) sum = sum ^ (8'h01 << $urandom_range(0, 7));
      body.push_back(sum);
      cut = body.size();
      if ($urandom_range(0, 99) < 8) cut = $urandom_range(0, body.size() - 1);
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      for (i = 0; i < cut; i++) send_item(body[i], 1'b0, 1'b0, '0);
      if ($urandom_range(0, 99) < 10) send_noise();
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // compare every accepted result with the oldest expected item
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_item.item_kind    = rsp_tuser;
         got_item.payload_byte = rsp_tdata[fpxc_pkg::RSP_PAYLOAD_LSB +: fpxc_pkg::BYTE_W];
         got_item.marker_seen  = rsp_tdata[fpxc_pkg::RSP_MARKER_LSB +: fpxc_pkg::BYTE_W];
         got_item.seq_number   = rsp_tdata[fpxc_pkg::RSP_SEQ_LSB +: fpxc_pkg::SEQ_W];
         got_item.frame_type   = rsp_tdata[fpxc_pkg::RSP_FTYPE_LSB +: fpxc_pkg::FTYPE_W];
         got_item.payload_len  = rsp_tdata[fpxc_pkg::RSP_LEN_LSB +: fpxc_pkg::LEN_W];
         got_item.status       = fpxc_pkg::status_type'(
                                    rsp_tdata[fpxc_pkg::RSP_STATUS_LSB +: fpxc_pkg::STATUS_W]);
         got_item.last         = rsp_tlast;
         if (frame_items_q.size() == 0) begin
            note_error({"item with nothing expected: ", fmt_item(got_item)});
         end else begin
            want_item = frame_items_q.pop_front();
            if (got_item !== want_item ||
                rsp_tdata[fpxc_pkg::RSP_TDATA_W-1:fpxc_pkg::RSP_FIELDS_W] !== '0)
               note_error({"expected ", fmt_item(want_item), " got ", fmt_item(got_item),
                           $sformatf(" pad %h",
                              rsp_tdata[fpxc_pkg::RSP_TDATA_W-1:fpxc_pkg::RSP_FIELDS_W])});
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_frame_parser_xor_checksum_top: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      int                          k;
      int                          ph;
      int                          target;
      logic [fpxc_pkg::LEN_W-1:0]  lim;
      stim_row_type                row;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // byte while idle after reset is ignored
      add_byte(8'h3c, 1'b0);
      // smallest marker, one data byte of all ones, good checksum
      add_byte(8'h00, 1'b1);
      add_byte(8'h04, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hff, 1'b0);
      add_byte(8'hfb, 1'b0);
      // largest marker, zero length with all header bits set
      add_byte(8'hff, 1'b1);
      add_byte(8'h03, 1'b0);
      add_status(8'hff, 8'hff, 5'd31, 5'd31, 6'd0, fpxc_pkg::ST_LEN_ZERO);
      // bytes after an error are ignored
      add_byte(8'h55, 1'b0);
      // longest frame dropped by a new start in the middle
      add_byte(8'h7e, 1'b1);
      add_byte(8'hfc, 1'b0);
      add_byte(8'h21, 1'b0);
      add_byte(8'h12, 1'b0);
      // two data bytes and a wrong checksum
      add_byte(8'h81, 1'b1);
      add_byte(8'h09, 1'b0);
      add_byte(8'h40, 1'b0);
      add_byte(8'haa, 1'b0);
      add_byte(8'h55, 1'b0);
      add_status(8'h00, 8'h81, 5'd10, 5'd0, 6'd2, fpxc_pkg::ST_SUM_BAD);
      // limit of zero: length one is too large, length zero still reads as zero
      add_cfg(6'd0);
      add_byte(8'h5a, 1'b1);
      add_byte(8'h04, 1'b0);
      add_status(8'h00, 8'h5a, 5'd0, 5'd0, 6'd1, fpxc_pkg::ST_LEN_LARGE);
      add_byte(8'ha5, 1'b1);
      add_byte(8'h00, 1'b0);
      add_status(8'h00, 8'ha5, 5'd0, 5'd0, 6'd0, fpxc_pkg::ST_LEN_ZERO);

      for (k = 0; k < plan.size(); k++) begin
         row = plan[k];
         if (row.cfg_write) write_limit(row.data[fpxc_pkg::LEN_W-1:0]);
         else send_item(row.data, row.start, row.pinned, row.want);
      end

      // random frames under a sweep of limits
      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: lim = 6'd63;
            1: lim = 6'd0;
            2: lim = 6'd1;
            3: lim = fpxc_pkg::LEN_W'($urandom_range(0, 63));
            4: lim = 6'd32;
            5: lim = 6'd21;
            6: lim = 6'd42;
            default: lim = 6'd63;
         endcase
         write_limit(lim);
         // one stretch with both sides running flat out
         send_idle_pct = (ph == 2) ? 0 : 6;
         recv_idle_pct = (ph == 2) ? 0 : 6;
         target = parsed_count + 240;
         while (parsed_count < target) begin
            if ($urandom_range(0, 99) < 88) send_frame(lim);
            else send_noise();
         end
      end

      drain();
      if (error_count == 0 && frame_items_q.size() == 0) begin
         $display("tb_frame_parser_xor_checksum_top: done, clean");
      end else begin
         $display("tb_frame_parser_xor_checksum_top: done, errors");
      end
      $finish;
   end

endmodule
